// ===== rtl/lddt_pkg.sv =====
package lddt_pkg;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] temp_word;
        logic [15:0] humi_word;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        compare_value;
        logic [15:0]        stored_duty;
        logic               led_enabled;
        logic [1:0]         alarm;
        logic signed [11:0] temp_tenths;
        logic [9:0]         humi_tenths;
        logic               applied;
    } t_out_item;

    // opcodes
    localparam logic OP_CMD    = 1'b0;
    localparam logic OP_SENSOR = 1'b1;

    // alarm codes
    localparam logic [1:0] ALARM_NONE = 2'd0;
    localparam logic [1:0] ALARM_WARN = 2'd1;
    localparam logic [1:0] ALARM_CRIT = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_WARN_THRESH = 2'd0;
    localparam logic [1:0] CFG_CRIT_THRESH = 2'd1;
    localparam logic [1:0] CFG_SAFE_DUTY   = 2'd2;
    localparam logic [1:0] CFG_PWM_MAX     = 2'd3;

    localparam logic signed [11:0] WARN_RST     = 12'sd410;
    localparam logic signed [11:0] CRIT_RST     = 12'sd430;
    localparam logic [15:0]        SAFE_RST     = 16'd200;
    localparam logic [15:0]        PWM_MAX_RST  = 16'd999;
    localparam logic [15:0]        DUTY_RST     = 16'd100;
    localparam logic [15:0]        COMPARE_RST  = 16'd100;

    // ASCII
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_UP_L = 8'h4C;
    localparam logic [7:0] CH_LO_L = 8'h6C;

    localparam logic [6:0] DIGIT_SAT = 7'd101;
    localparam logic [6:0] LEVEL_MAX = 7'd100;

    localparam logic [10:0]        TEMP_SPAN   = 11'd1750;
    localparam logic [9:0]         HUMI_SPAN   = 10'd1000;
    localparam logic signed [11:0] TEMP_OFFSET = 12'sd450;

    // 2^26 / 25 rounded up; exact for quotients of 21-bit values
    localparam logic [21:0] RECIP_25 = 22'd2684355;

    // parser result for the byte in flight
    typedef struct packed {
        logic       done;
        logic [6:0] level;
    } t_fin;

    typedef struct packed {
        logic        is_sensor;
        logic        done;
        logic [6:0]  level;
        logic [26:0] t_prod;
        logic [25:0] h_prod;
    } t_s2;

    typedef struct packed {
        logic               is_sensor;
        logic               done;
        logic [6:0]         level;
        logic signed [11:0] temp;
        logic [9:0]         humi;
        logic [22:0]        prod;
    } t_s3;

    typedef struct packed {
        logic               is_sensor;
        logic               done;
        logic               led_on;
        logic [15:0]        duty_new;
        logic signed [11:0] temp;
        logic [9:0]         humi;
        logic [1:0]         alarm;
    } t_s4;

    // floor(x / 65535): q0 = x >> 16 leaves remainder x[15:0] + q0, below 2 * 65535
    function automatic logic [10:0] f_div65535(input logic [26:0] x);
        logic [10:0] q0;
        logic [16:0] r;
        q0 = x[26:16];
        r  = {1'b0, x[15:0]} + {6'b0, q0};
        if (r >= 17'd65535) begin
            return q0 + 11'd1;
        end
        return q0;
    endfunction

    // floor(x / 100) = floor(floor(x / 4) / 25)
    function automatic logic [15:0] f_div100(input logic [22:0] x);
        logic [42:0] p;
        p = 43'(x[22:2]) * 43'(RECIP_25);
        return p[41:26];
    endfunction

endpackage

// ===== rtl/led_dimmer_with_thermal_guard_unit.sv =====
// Pipeline: input register, parse/scale, divide and duty/threshold stages, output register last.
// Throughput: one item per cycle; only the output register's stall holds the pipe.
// Reset (synchronous, active low) loads the register defaults, duty and compare 100,
// LED on, clears the message parser and the last temperature and humidity.
module led_dimmer_with_thermal_guard_unit
    import lddt_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    logic signed [11:0] r_warn;
    logic signed [11:0] r_crit;
    logic [15:0]        r_safe;
    logic [15:0]        r_pwm_max;

    logic     r_v1, r_v2, r_v3, r_v4;
    t_in_item r_s1;
    t_s2      r_s2, n_s2;
    t_s3      r_s3, n_s3;
    t_s4      r_s4, n_s4;
    logic     en1, en2, en3, en4, en5;
    logic     take;
    t_fin     fin;
    logic [10:0] t_q;
    logic [9:0]  h_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn    <= WARN_RST;
            r_crit    <= CRIT_RST;
            r_safe    <= SAFE_RST;
            r_pwm_max <= PWM_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WARN_THRESH: r_warn    <= i_cfg_wdata[11:0];
                CFG_CRIT_THRESH: r_crit    <= i_cfg_wdata[11:0];
                CFG_SAFE_DUTY:   r_safe    <= i_cfg_wdata;
                CFG_PWM_MAX:     r_pwm_max <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // each stage advances when empty or when the next one takes its beat
    assign en4        = !r_v4 || en5;
    assign en3        = !r_v3 || en4;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;

    assign take = r_v1 && en2 && (r_s1.opcode == OP_CMD);

    lddt_msg_parser #(
        .MaxMsgBytes(MAX_MSG_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (r_s1.data_byte),
        .i_last_byte (r_s1.last_byte),
        .o_fin       (fin)
    );

    always_comb begin
        n_s2.is_sensor = (r_s1.opcode == OP_SENSOR);
        n_s2.done      = fin.done;
        n_s2.level     = fin.level;
        n_s2.t_prod    = 27'(r_s1.temp_word) * 27'(TEMP_SPAN);
        n_s2.h_prod    = 26'(r_s1.humi_word) * 26'(HUMI_SPAN);
    end

    assign t_q = f_div65535(r_s2.t_prod);
    assign h_q = 10'(f_div65535({1'b0, r_s2.h_prod}));

    always_comb begin
        n_s3.is_sensor = r_s2.is_sensor;
        n_s3.done      = r_s2.done;
        n_s3.level     = r_s2.level;
        n_s3.temp      = $signed({1'b0, t_q}) - TEMP_OFFSET;
        n_s3.humi      = h_q;
        n_s3.prod      = 23'(r_s2.level) * 23'(r_pwm_max);
    end

    always_comb begin
        n_s4.is_sensor = r_s3.is_sensor;
        n_s4.done      = r_s3.done;
        n_s4.led_on    = (r_s3.level != '0);
        n_s4.duty_new  = f_div100(r_s3.prod);
        n_s4.temp      = r_s3.temp;
        n_s4.humi      = r_s3.humi;
        if ($signed(r_s3.temp) > r_crit) begin
            n_s4.alarm = ALARM_CRIT;
        end else if ($signed(r_s3.temp) > r_warn) begin
            n_s4.alarm = ALARM_WARN;
        end else begin
            n_s4.alarm = ALARM_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= i_in_item;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
        if (en3) begin
            r_s3 <= n_s3;
        end
        if (en4) begin
            r_s4 <= n_s4;
        end
    end

    lddt_led_state u_led_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v4),
        .i_s4        (r_s4),
        .i_safe_duty (r_safe),
        .o_ready     (en5),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/lddt_msg_parser.sv =====
module lddt_msg_parser
    import lddt_pkg::*;
#(
    parameter int MaxMsgBytes = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_fin       o_fin
);

    localparam int CntW = $clog2(MaxMsgBytes + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MaxMsgBytes);
    localparam logic [CntW-1:0] CntMin = CntW'(2);

    logic [CntW-1:0] r_count, n_count;
    logic [7:0]      r_type, n_type;
    logic [6:0]      r_digit, n_digit;
    logic            r_ended, n_ended;
    logic [9:0]      digit_calc;
    logic            is_digit;
    logic            is_eol;

    assign is_digit   = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
    assign is_eol     = (i_data_byte == CH_LF) || (i_data_byte == CH_CR);
    assign digit_calc = 10'(r_digit) * 10'd10 + 10'(i_data_byte - CH_ZERO);

    always_comb begin
        n_count = r_count;
        n_type  = r_type;
        n_digit = r_digit;
        n_ended = r_ended;
        // drop bytes past the message limit
        if (r_count < CntMax) begin
            if (r_count == '0) begin
                n_type = i_data_byte;
            end else if (!r_ended) begin
                if (is_digit) begin
                    n_digit = (digit_calc > 10'(DIGIT_SAT)) ? DIGIT_SAT : digit_calc[6:0];
                end else if (is_eol) begin
                    n_ended = 1'b1;
                end
            end
            n_count = r_count + 1'b1;
        end

        o_fin.done  = i_last_byte && (n_count >= CntMin) &&
                      ((n_type == CH_UP_L) || (n_type == CH_LO_L));
        o_fin.level = (n_digit > LEVEL_MAX) ? LEVEL_MAX : n_digit;

        if (i_last_byte) begin
            n_count = '0;
            n_type  = '0;
            n_digit = '0;
            n_ended = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_type  <= '0;
            r_digit <= '0;
            r_ended <= 1'b0;
        end else if (i_take) begin
            r_count <= n_count;
            r_type  <= n_type;
            r_digit <= n_digit;
            r_ended <= n_ended;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntMax)
        else $error("byte count past message limit");

    a_digit_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit <= DIGIT_SAT)
        else $error("digit accumulator past saturation");

    a_ended_after_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |-> (r_count >= CntMin))
        else $error("line end flagged before the type byte");

endmodule

// ===== rtl/lddt_led_state.sv =====
module lddt_led_state
    import lddt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_s4         i_s4,
    input  logic [15:0] i_safe_duty,
    output logic        o_ready,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_out_item   o_out_item
);

    logic               r_valid;
    logic [15:0]        r_duty, n_duty;
    logic               r_led, n_led;
    logic [15:0]        r_cmp, n_cmp;
    logic signed [11:0] r_temp, n_temp;
    logic [9:0]         r_humi, n_humi;
    logic [1:0]         r_alarm, n_alarm;
    logic               r_applied, n_applied;
    logic               load;

    assign o_ready = !r_valid || i_out_ready;
    assign load    = o_ready && i_valid;

    always_comb begin
        n_duty    = r_duty;
        n_led     = r_led;
        n_cmp     = r_cmp;
        n_temp    = r_temp;
        n_humi    = r_humi;
        n_alarm   = ALARM_NONE;
        n_applied = 1'b0;
        if (i_s4.is_sensor) begin
            n_temp  = i_s4.temp;
            n_humi  = i_s4.humi;
            n_alarm = i_s4.alarm;
            case (i_s4.alarm)
                ALARM_CRIT: begin
                    n_duty = '0;
                    n_led  = 1'b0;
                    n_cmp  = '0;
                end
                ALARM_WARN: begin
                    // compare stays 0 while the LED is off
                    n_duty = i_safe_duty;
                    n_cmp  = r_led ? i_safe_duty : '0;
                end
                default: ;
            endcase
        end else if (i_s4.done) begin
            n_duty    = i_s4.duty_new;
            n_led     = i_s4.led_on;
            n_cmp     = i_s4.led_on ? i_s4.duty_new : '0;
            n_applied = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_duty  <= DUTY_RST;
            r_led   <= 1'b1;
            r_cmp   <= COMPARE_RST;
            r_temp  <= '0;
            r_humi  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_duty <= n_duty;
                r_led  <= n_led;
                r_cmp  <= n_cmp;
                r_temp <= n_temp;
                r_humi <= n_humi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_alarm   <= n_alarm;
            r_applied <= n_applied;
        end
    end

    assign o_out_valid              = r_valid;
    assign o_out_item.compare_value = r_cmp;
    assign o_out_item.stored_duty   = r_duty;
    assign o_out_item.led_enabled   = r_led;
    assign o_out_item.alarm         = r_alarm;
    assign o_out_item.temp_tenths   = r_temp;
    assign o_out_item.humi_tenths   = r_humi;
    assign o_out_item.applied       = r_applied;

    a_crit_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_alarm == ALARM_CRIT)) |-> (!r_led && (r_cmp == '0)))
        else $error("critical beat with LED still driven");

    a_cmp_needs_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmp != '0) |-> r_led)
        else $error("nonzero compare with LED off");

    a_applied_no_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_applied) |-> (r_alarm == ALARM_NONE))
        else $error("applied command beat carries an alarm");

endmodule

// ===== test/dimmer_checker.sv =====
module dimmer_checker
    import lddt_pkg::*;
#(
    parameter int MAX_MSG_BYTES = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    int          warn_thr;
    int          crit_thr;
    logic [15:0] safe_level;
    logic [15:0] full_scale;

    // lamp and parser state
    logic [15:0] duty_held;
    logic [15:0] compare_now;
    logic        lamp_on;
    int unsigned msg_len;
    logic [7:0]  msg_kind;
    int unsigned msg_level;
    logic        msg_closed;
    int          temp_now;
    int unsigned humi_now;

    t_out_item   due_results[$];
    int          fails = 0;

    function automatic t_out_item dimmer_next(input t_in_item it);
        t_out_item   r;
        int unsigned lvl;
        logic [1:0]  alarm;
        logic        done;
        alarm = ALARM_NONE;
        done  = 1'b0;
        if (it.opcode == OP_CMD) begin
            // bytes past the message limit are dropped, but the end mark still counts
            if (msg_len < MAX_MSG_BYTES) begin
                if (msg_len == 0) begin
                    msg_kind = it.data_byte;
                end else if (!msg_closed) begin
                    if (it.data_byte >= CH_ZERO && it.data_byte <= CH_NINE) begin
                        lvl = msg_level * 10 + (it.data_byte - CH_ZERO);
                        msg_level = (lvl > DIGIT_SAT) ? DIGIT_SAT : lvl;
                    end else if (it.data_byte == CH_LF || it.data_byte == CH_CR) begin
                        msg_closed = 1'b1;
                    end
                end
                msg_len++;
            end
            if (it.last_byte) begin
                if (msg_len >= 2 && (msg_kind == CH_UP_L || msg_kind == CH_LO_L)) begin
                    lvl         = (msg_level > LEVEL_MAX) ? LEVEL_MAX : msg_level;
                    duty_held   = 16'((lvl * full_scale) / 100);
                    lamp_on     = (lvl > 0);
                    compare_now = lamp_on ? duty_held : 16'd0;
                    done        = 1'b1;
                end
                msg_len    = 0;
                msg_kind   = '0;
                msg_level  = 0;
                msg_closed = 1'b0;
            end
        end else begin
            temp_now = -450 + int'((32'd1750 * it.temp_word) / 32'd65535);
            humi_now = (32'd1000 * it.humi_word) / 32'd65535;
            if (temp_now > crit_thr) begin
                duty_held   = '0;
                lamp_on     = 1'b0;
                compare_now = '0;
                alarm       = ALARM_CRIT;
            end else if (temp_now > warn_thr) begin
                // compare stays at zero while the lamp is off
                duty_held   = safe_level;
                compare_now = lamp_on ? safe_level : 16'd0;
                alarm       = ALARM_WARN;
            end
        end
        r.compare_value = compare_now;
        r.stored_duty   = duty_held;
        r.led_enabled   = lamp_on;
        r.alarm         = alarm;
        r.temp_tenths   = temp_now[11:0];
        r.humi_tenths   = humi_now[9:0];
        r.applied       = done;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fails++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            warn_thr    = int'(WARN_RST);
            crit_thr    = int'(CRIT_RST);
            safe_level  = SAFE_RST;
            full_scale  = PWM_MAX_RST;
            duty_held   = DUTY_RST;
            compare_now = COMPARE_RST;
            lamp_on     = 1'b1;
            msg_len     = 0;
            msg_kind    = '0;
            msg_level   = 0;
            msg_closed  = 1'b0;
            temp_now    = 0;
            humi_now    = 0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WARN_THRESH: warn_thr = int'($signed(i_cfg_wdata[11:0]));
                    CFG_CRIT_THRESH: crit_thr = int'($signed(i_cfg_wdata[11:0]));
                    CFG_SAFE_DUTY:   safe_level = i_cfg_wdata;
                    CFG_PWM_MAX:     full_scale = i_cfg_wdata;
                    default: ;
                endcase
            end
            // retire the result beat before queuing this edge's input beat
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t: result beat expected none actual %h", $time, i_out_item);
                end else begin
                    want = due_results.pop_front();
                    check_field("compare_value", want.compare_value, i_out_item.compare_value);
                    check_field("stored_duty", want.stored_duty, i_out_item.stored_duty);
                    check_field("led_enabled", want.led_enabled, i_out_item.led_enabled);
                    check_field("alarm", want.alarm, i_out_item.alarm);
                    check_field("temp_tenths", $signed(want.temp_tenths),
                                $signed(i_out_item.temp_tenths));
                    check_field("humi_tenths", want.humi_tenths, i_out_item.humi_tenths);
                    check_field("applied", want.applied, i_out_item.applied);
                end
            end
            if (i_in_valid && i_in_ready) begin
                due_results.push_back(dimmer_next(i_in_item));
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
    end

endmodule

// ===== test/tb.sv =====
module tb
    import lddt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BEATS   = 530;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = CFG_WARN_THRESH;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    int          pending;
    int          fail_count;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int beats_sent    = 0;
    int cur_warn      = int'(WARN_RST);
    int cur_crit      = int'(CRIT_RST);

    led_dimmer_with_thermal_guard_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    dimmer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_in_item cmd_beat(input logic [7:0] ch, input logic fin);
        t_in_item it;
        it.opcode    = OP_CMD;
        it.data_byte = ch;
        it.last_byte = fin;
        it.temp_word = 16'($urandom);
        it.humi_word = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item sensor_beat(input logic [15:0] rt, input logic [15:0] rh);
        t_in_item it;
        it.opcode    = OP_SENSOR;
        it.data_byte = 8'($urandom);
        it.last_byte = 1'($urandom);
        it.temp_word = rt;
        it.humi_word = rh;
        return it;
    endfunction

    // half uniform, half aimed just around one of the thresholds
    function automatic t_in_item random_sensor();
        int thr;
        int raw;
        if ($urandom_range(1) == 1) begin
            raw = $urandom_range(65535);
        end else begin
            thr = ($urandom_range(1) == 1) ? cur_warn : cur_crit;
            raw = ((thr + 450) * 65535) / 1750;
            raw = raw + int'($urandom_range(80)) - 40;
            if (raw < 0) raw = 0;
            if (raw > 65535) raw = 65535;
        end
        return sensor_beat(16'(raw), 16'($urandom));
    endfunction

    task automatic send_beat(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_beat(cmd_beat(s[k], k == s.len() - 1));
        end
    endtask

    task automatic send_random_message();
        int          kind;
        int          len;
        int          r;
        logic [7:0]  ch;
        logic        fin;
        kind = $urandom_range(99);
        if (kind < 3) begin
            len = $urandom_range(80, 64);
        end else if (kind < 8) begin
            len = 1;
        end else begin
            len = $urandom_range(6, 2);
        end
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 15) send_beat(random_sensor());
            r = $urandom_range(99);
            if (k == 0) begin
                if (r < 45) ch = CH_UP_L;
                else if (r < 75) ch = CH_LO_L;
                else ch = 8'($urandom);
            end else begin
                if (r < 75) ch = CH_ZERO + 8'($urandom_range(9));
                else if (r < 79) ch = CH_CR;
                else if (r < 83) ch = CH_LF;
                else ch = 8'($urandom);
            end
            // a stray end mark now and then breaks a message early
            fin = (k == len - 1) || ($urandom_range(199) == 0);
            send_beat(cmd_beat(ch, fin));
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input int warn, input int crit, input int safe, input int full);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_WARN_THRESH;
        cfg_wdata <= 16'(warn);
        @(posedge clk);
        cfg_idx   <= CFG_CRIT_THRESH;
        cfg_wdata <= 16'(crit);
        @(posedge clk);
        cfg_idx   <= CFG_SAFE_DUTY;
        cfg_wdata <= 16'(safe);
        @(posedge clk);
        cfg_idx   <= CFG_PWM_MAX;
        cfg_wdata <= 16'(full);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_warn = warn;
        cur_crit = crit;
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct, input int warn,
                             input int crit, input int safe, input int full, input bit press);
        int target;
        settle();
        write_regs(warn, crit, safe, full);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        if (press) hold_asks++;
        target = beats_sent + PHASE_BEATS;
        while (beats_sent < target) send_random_message();
    endtask

    initial begin : receiver
        int seen;
        seen = 0;
        forever begin
            @(posedge clk);
            if (hold_asks != seen) begin
                // hold off so the pipe backs up into the input
                seen = hold_asks;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int warn_r;
        int crit_r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 31;
        recv_idle_pct = 61;

        // directed: reset settings
        send_text("L");
        send_text("X5");
        send_text("L9a9");
        send_beat(sensor_beat(16'h0000, 16'hFFFF));
        // sensor inside a message, then a line end hides the trailing digit
        send_beat(cmd_beat(CH_UP_L, 1'b0));
        send_beat(cmd_beat(CH_ZERO + 8'd5, 1'b0));
        send_beat(sensor_beat(16'd20000, 16'd30000));
        send_beat(cmd_beat(CH_CR, 1'b0));
        send_beat(cmd_beat(CH_ZERO + 8'd7, 1'b1));
        send_beat(sensor_beat(16'hFFFF, 16'h0000));
        send_beat(sensor_beat(16'd32600, 16'd40000));
        send_text("l1234");
        send_text("l100");

        run_phase(31, 61, -450, 1300, 0, 65535, 1'b0);
        run_phase(61, 31, 1300, -450, 65535, 1, 1'b0);
        warn_r = int'($urandom_range(1750)) - 450;
        crit_r = warn_r + int'($urandom_range(60));
        if (crit_r > 1300) crit_r = 1300;
        run_phase(0, 0, warn_r, crit_r, $urandom_range(65535), $urandom_range(65535, 1), 1'b1);

        settle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== led_dimmer_with_thermal_guard_unit.f =====
rtl/lddt_pkg.sv
rtl/lddt_msg_parser.sv
rtl/lddt_led_state.sv
rtl/led_dimmer_with_thermal_guard_unit.sv
test/dimmer_checker.sv
test/tb.sv
